// File: rtl/s1bh_pkg.sv
// ----------------------------------------------------------------------------
// s1bh_pkg
// Shared types, constants and helpers for the SHA-1 byte stream hasher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package s1bh_pkg;

    // round constants, one per group of twenty rounds
    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    // initial chaining value
    localparam logic [31:0] H_INIT [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam int ROUND_W = 7;
    localparam logic [ROUND_W-1:0] ROUND_LAST = 7'd79;
    localparam logic [ROUND_W-1:0] PHASE1_START = 7'd20;
    localparam logic [ROUND_W-1:0] PHASE2_START = 7'd40;
    localparam logic [ROUND_W-1:0] PHASE3_START = 7'd60;

    // byte slots inside a 64-byte block
    localparam logic [5:0] POS_LEN_START = 6'd56;
    localparam logic [5:0] POS_BEFORE_LEN = 6'd55;
    localparam logic [5:0] POS_LAST = 6'd63;

    // digest word numbering
    localparam logic [2:0] WORD_LAST = 3'd4;

    // round working variables
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } wv_t;

    function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] n);
        logic [5:0] m;
        m = 6'd32 - {1'b0, n};
        return (v << n) | (v >> m);
    endfunction

endpackage

// File: rtl/s1bh_round.sv
// ----------------------------------------------------------------------------
// s1bh_round
// One SHA-1 round: boolean function, constant select and the five-term add.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module s1bh_round
    import s1bh_pkg::*;
(
    input  wv_t                wv_in,
    input  logic [31:0]        w_in,
    input  logic [ROUND_W-1:0] round_in,
    output wv_t                wv_out
);

    logic [31:0] f;
    logic [31:0] k;

    // boolean function and constant by round group
    always_comb begin
        priority if (round_in < PHASE1_START) begin
            f = (wv_in.b & wv_in.c) | (~wv_in.b & wv_in.d);
            k = K0;
        end else if (round_in < PHASE2_START) begin
            f = wv_in.b ^ wv_in.c ^ wv_in.d;
            k = K1;
        end else if (round_in < PHASE3_START) begin
            f = (wv_in.b & wv_in.c) | (wv_in.b & wv_in.d) | (wv_in.c & wv_in.d);
            k = K2;
        end else begin
            f = wv_in.b ^ wv_in.c ^ wv_in.d;
            k = K3;
        end
    end

    // rotate the variables, new a from the sum
    always_comb begin
        wv_out.a = rotl32(wv_in.a, 5'd5) + f + wv_in.e + w_in + k;
        wv_out.b = wv_in.a;
        wv_out.c = rotl32(wv_in.b, 5'd30);
        wv_out.d = wv_in.c;
        wv_out.e = wv_in.d;
    end

endmodule

// File: rtl/sha1_byte_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha1_byte_stream_hasher
// SHA-1 over a byte stream, one round per cycle on a shared round unit.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one message byte per beat in s_tdata, s_tuser high when the
//   byte is real, s_tlast high on the final beat. A beat with s_tuser low and
//   s_tlast high ends the message without a byte (empty message possible).
//   m_ channel: five digest beats, word 0 (most significant) first, word index
//   in m_tuser, m_tlast on word 4.
//   Timing: the beat that fills a 64-byte block is followed by the round
//   phase (ST_ROUND, rounds 0 to 79) and the chaining add (ST_ADD) with
//   s_tready low, after which input bytes are taken again. After the last
//   beat the padding is pushed one byte per cycle between compressions
//   (ST_PAD_ZERO pauses at slot 56 before the length field unless the mark
//   lands in slot 55), with one or two more compressions. The five words
//   then leave through the output register one per cycle while m_tready
//   is high.
//   Reset loads the initial chaining value and clears the length; after the
//   fifth word is loaded the same happens and s_tready returns high.
//   A stalled receiver holds the current word; the block waits in its
//   output phase and takes no new beat until all five words are loaded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha1_byte_stream_hasher
    import s1bh_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] message_byte
    input  logic        s_tuser,   // [0] has_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_index
    output logic        m_tlast
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD_MARK,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_OUT
    } state_t;

    state_t              state_reg, state_next;
    state_t              ret_reg, ret_next;
    logic [ROUND_W-1:0]  round_reg, round_next;
    logic [5:0]          pos_reg, pos_next;
    logic [63:0]         count_reg, count_next;
    logic [511:0]        buf_reg, buf_next;
    logic [31:0]         chain_reg [5];
    logic [31:0]         chain_next [5];
    wv_t                 wv_reg, wv_next;
    wv_t                 wv_round;
    logic [2:0]          idx_reg, idx_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [31:0]         m_tdata_reg, m_tdata_next;
    logic [2:0]          m_tuser_reg, m_tuser_next;
    logic                m_tlast_reg, m_tlast_next;

    logic                push_en;
    logic [7:0]          push_byte;
    logic                start_comp;
    logic [31:0]         sched_new;
    logic [7:0]          len_byte;
    logic [2:0]          len_sel;

    // schedule taps: word k of the window sits at buf_reg[511-32k -: 32]
    assign sched_new = rotl32(buf_reg[511-32*13 -: 32] ^ buf_reg[511-32*8 -: 32]
                            ^ buf_reg[511-32*2 -: 32] ^ buf_reg[511:480], 5'd1);

    // length byte for the current slot, most significant first
    assign len_sel  = 3'd7 - pos_reg[2:0];
    assign len_byte = count_reg[{len_sel, 3'b000} +: 8];

    s1bh_round u_round (
        .wv_in    (wv_reg),
        .w_in     (buf_reg[511:480]),
        .round_in (round_reg),
        .wv_out   (wv_round)
    );

    // sequencer and datapath next values
    always_comb begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        round_next    = round_reg;
        pos_next      = pos_reg;
        count_next    = count_reg;
        buf_next      = buf_reg;
        chain_next    = chain_reg;
        wv_next       = wv_reg;
        idx_next      = idx_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        push_en       = 1'b0;
        push_byte     = '0;
        start_comp    = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser) begin
                        push_en    = 1'b1;
                        push_byte  = s_tdata;
                        count_next = count_reg + 64'd8;
                    end
                    if (s_tuser && pos_reg == POS_LAST) begin
                        start_comp = 1'b1;
                        ret_next   = s_tlast ? ST_PAD_MARK : ST_IDLE;
                    end else if (s_tlast) begin
                        state_next = ST_PAD_MARK;
                    end
                end
            end
            ST_ROUND: begin
                buf_next   = {buf_reg[479:0], sched_new};
                wv_next    = wv_round;
                round_next = round_reg + 1'b1;
                if (round_reg == ROUND_LAST) begin
                    round_next = '0;
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                chain_next[0] = chain_reg[0] + wv_reg.a;
                chain_next[1] = chain_reg[1] + wv_reg.b;
                chain_next[2] = chain_reg[2] + wv_reg.c;
                chain_next[3] = chain_reg[3] + wv_reg.d;
                chain_next[4] = chain_reg[4] + wv_reg.e;
                state_next    = ret_reg;
            end
            ST_PAD_MARK: begin
                push_en   = 1'b1;
                push_byte = PAD_MARK;
                if (pos_reg == POS_LAST) begin
                    start_comp = 1'b1;
                    ret_next   = ST_PAD_ZERO;
                end else if (pos_reg == POS_BEFORE_LEN) begin
                    state_next = ST_PAD_LEN;
                end else begin
                    state_next = ST_PAD_ZERO;
                end
            end
            ST_PAD_ZERO: begin
                if (pos_reg == POS_LEN_START) begin
                    state_next = ST_PAD_LEN;
                end else begin
                    push_en = 1'b1;
                    if (pos_reg == POS_LAST) begin
                        start_comp = 1'b1;
                        ret_next   = ST_PAD_ZERO;
                    end
                end
            end
            ST_PAD_LEN: begin
                push_en   = 1'b1;
                push_byte = len_byte;
                if (pos_reg == POS_LAST) begin
                    start_comp = 1'b1;
                    ret_next   = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = chain_reg[idx_reg];
                    m_tuser_next  = idx_reg;
                    m_tlast_next  = (idx_reg == WORD_LAST);
                    idx_next      = idx_reg + 1'b1;
                    if (idx_reg == WORD_LAST) begin
                        idx_next   = '0;
                        chain_next = H_INIT;
                        count_next = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // byte insert into the block buffer
        if (push_en) begin
            buf_next = {buf_reg[503:0], push_byte};
            pos_next = pos_reg + 1'b1;
        end

        // full block: load working variables and start the rounds
        if (start_comp) begin
            wv_next    = {chain_reg[0], chain_reg[1], chain_reg[2], chain_reg[3],
                          chain_reg[4]};
            round_next = '0;
            state_next = ST_ROUND;
        end
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        buf_reg     <= buf_next;
        wv_reg      <= wv_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            ret_reg      <= ST_IDLE;
            round_reg    <= '0;
            pos_reg      <= '0;
            count_reg    <= '0;
            chain_reg    <= H_INIT;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ret_reg      <= ret_next;
            round_reg    <= round_next;
            pos_reg      <= pos_next;
            count_reg    <= count_next;
            chain_reg    <= chain_next;
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // round counter never passes the last round
    a_round_range: assert property (@(posedge aclk) disable iff (!aresetn)
        round_reg <= ROUND_LAST)
        else $error("round counter out of range");

    // the chaining add follows only the final round
    a_add_after_rounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND && state_next == ST_ADD) |-> round_reg == ROUND_LAST)
        else $error("compression ended early");

    // length bytes only go into the last eight slots
    a_len_slots: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PAD_LEN) |-> pos_reg[5:3] == 3'b111)
        else $error("length byte outside the length field");

    // the final digest beat carries word index four
    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> m_tuser == WORD_LAST)
        else $error("last beat with wrong word index");

    // a new digest word is loaded only from the output phase
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_next && !(m_tvalid_reg && !m_tready)) |-> state_reg == ST_OUT)
        else $error("digest word loaded outside the output phase");

endmodule

// File: tb/tb_sha1_byte_stream_hasher.sv
// ----------------------------------------------------------------------------
// tb_sha1_byte_stream_hasher
// Self-checking bench for the SHA-1 byte stream hasher. Messages go in one
// byte per beat. A scoreboard runs its own SHA-1 over every accepted input
// beat and queues the five digest words that each message should produce.
// The words that come out are checked against that queue in order. Both
// channels idle and stall at random. One long receiver hold-off backs the
// block up so that it stalls its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// one expected digest beat
typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
} digest_beat_t;

// running SHA-1 digest of the accepted beats, plus the queue of digest words
class sha1_scoreboard;
    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;
    localparam logic [31:0] RK0 = 32'h5A827999;
    localparam logic [31:0] RK1 = 32'h6ED9EBA1;
    localparam logic [31:0] RK2 = 32'h8F1BBCDC;
    localparam logic [31:0] RK3 = 32'hCA62C1D6;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [5:0]  LEN_SLOT = 6'd56;

    logic [31:0]  hash_state [5];
    logic [31:0]  block_words [16];
    logic [63:0]  msg_bits;
    logic [5:0]   slot;
    digest_beat_t digest_q [$];
    int unsigned  n_errors;

    function new();
        start_message();
        n_errors = 0;
    endfunction

    function void start_message();
        hash_state[0] = IV0;
        hash_state[1] = IV1;
        hash_state[2] = IV2;
        hash_state[3] = IV3;
        hash_state[4] = IV4;
        for (int i = 0; i < 16; i++) block_words[i] = '0;
        msg_bits = '0;
        slot = '0;
    endfunction

    function logic [31:0] rol(logic [31:0] v, int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    // 80 rounds over the block buffer, schedule expanded in place
    function void compress_block();
        logic [31:0] a, b, c, d, e, f, k, w, sum;
        a = hash_state[0];
        b = hash_state[1];
        c = hash_state[2];
        d = hash_state[3];
        e = hash_state[4];
        for (int r = 0; r < 80; r++) begin
            if (r >= 16) begin
                w = block_words[(r - 3) & 15] ^ block_words[(r - 8) & 15]
                  ^ block_words[(r - 14) & 15] ^ block_words[r & 15];
                block_words[r & 15] = rol(w, 1);
            end
            w = block_words[r & 15];
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = RK0;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = RK1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = RK2;
            end else begin
                f = b ^ c ^ d;
                k = RK3;
            end
            sum = rol(a, 5) + f + e + w + k;
            e = d;
            d = c;
            c = rol(b, 30);
            b = a;
            a = sum;
        end
        hash_state[0] += a;
        hash_state[1] += b;
        hash_state[2] += c;
        hash_state[3] += d;
        hash_state[4] += e;
    endfunction

    // big-endian byte packing, compression once 64 bytes are in
    function void push_byte(logic [7:0] value);
        block_words[slot[5:2]][31 - 8 * slot[1:0] -: 8] = value;
        slot = slot + 6'd1;
        if (slot == 6'd0) compress_block();
    endfunction

    // accepted input beat: absorb it, and on the last beat queue the digest
    function void note_input(logic [7:0] data, logic has_byte, logic is_last);
        logic [63:0] len;
        if (has_byte) begin
            push_byte(data);
            msg_bits += 64'd8;
        end
        if (!is_last) return;
        len = msg_bits;
        push_byte(PAD_BYTE);
        while (slot != LEN_SLOT) push_byte(8'h00);
        for (int i = 0; i < 8; i++) push_byte(len[63 - 8 * i -: 8]);
        for (int i = 0; i < 5; i++) digest_q.push_back('{hash_state[i], 3'(i), i == 4});
        start_message();
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
        n_errors++;
    endtask

    // accepted output beat against the oldest queued digest word
    task check_result(logic [31:0] data, logic [2:0] index, logic last);
        digest_beat_t want;
        if (digest_q.size() == 0) begin
            report("unexpected digest beat", data, 32'h0);
            return;
        end
        want = digest_q.pop_front();
        if (data !== want.word) report("digest word", data, want.word);
        if (index !== want.index) report("word index", 32'(index), 32'(want.index));
        if (last !== want.last) report("last flag", 32'(last), 32'(want.last));
    endtask
endclass

module tb_sha1_byte_stream_hasher;

    localparam int TX_ITEMS = 270;
    localparam int HOLD_AT_BEAT = 5;
    localparam int HOLD_CYCLES = 300;
    localparam int END_CYCLES = 20;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    sha1_scoreboard sb = new();
    int  n_items = 0;
    bit  tx_quiet = 0;
    bit  rx_quiet = 0;

    sha1_byte_stream_hasher u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // clock
    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // byte values leaning toward the extremes
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // message lengths: mostly short, some around the padding boundaries
    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) begin
            case ($urandom_range(0, 5))
                0: return 55;
                1: return 56;
                2: return 57;
                3: return 63;
                4: return 64;
                default: return 65;
            endcase
        end
        if (r == 2) return $urandom_range(11, 48);
        return $urandom_range(0, 10);
    endfunction

    // one input beat, after a random gap, held until accepted
    task send_beat(input logic [7:0] data, input logic has_byte, input logic is_last);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 4);
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= has_byte;
        s_tlast  <= is_last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(data, has_byte, is_last);
        if (has_byte || is_last) n_items++;
    endtask

    // stop offering and wait for every queued digest word
    task drain_digests();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.digest_q.size() != 0) @(posedge aclk);
    endtask

    // whole message with idle beats sprinkled in, optionally closed by an empty beat
    task send_message(input int len, input bit empty_end);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 7) == 0) send_beat(pick_byte(), 1'b0, 1'b0);
            send_beat(pick_byte(), 1'b1, (i == len - 1) && !empty_end);
        end
        if (empty_end || len == 0) send_beat(pick_byte(), 1'b0, 1'b1);
    endtask

    // stimulus
    initial begin
        int  len;
        bit  empty_end;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        s_tlast  = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // empty message
        send_beat(8'h3C, 1'b0, 1'b1);
        // idle beat, then a single zero byte
        send_beat(8'hA5, 1'b0, 1'b0);
        send_beat(8'h00, 1'b1, 1'b1);
        // single all-ones byte
        send_beat(8'hFF, 1'b1, 1'b1);
        // "abc"
        send_beat(8'h61, 1'b1, 1'b0);
        send_beat(8'h62, 1'b1, 1'b0);
        send_beat(8'h63, 1'b1, 1'b1);
        // idle beat in the middle, empty beat closes the message
        send_beat(8'h80, 1'b1, 1'b0);
        send_beat(8'h7F, 1'b0, 1'b0);
        send_beat(8'h01, 1'b1, 1'b0);
        send_beat(8'h55, 1'b0, 1'b1);
        drain_digests();

        // random messages
        while (n_items < TX_ITEMS) begin
            tx_quiet  = ($urandom_range(0, 3) == 0);
            len       = pick_length();
            empty_end = ($urandom_range(0, 3) == 0);
            send_message(len, empty_end);
            if ($urandom_range(0, 5) == 0) drain_digests();
        end

        drain_digests();
        repeat (END_CYCLES) @(posedge aclk);
        if (sb.n_errors == 0 && sb.digest_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // receiver with random stalls and one long hold-off
    initial begin
        int hold;
        int n_beats;
        n_beats  = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (n_beats == HOLD_AT_BEAT) hold = HOLD_CYCLES;
            else hold = rx_quiet ? 0 : $urandom_range(0, 4);
            if (hold != 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            sb.check_result(m_tdata, m_tuser, m_tlast);
            n_beats++;
            if (n_beats % 20 == 0) rx_quiet = ($urandom_range(0, 2) == 0);
        end
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
